// File: sv/blbt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blbt_pkg
// Shared widths, register layout, codes and constants of the batch throttle.
// ---------------------------------------------------------------------------
package blbt_pkg;

    // field widths
    localparam int CAP_W     = 24;
    localparam int PCT_W     = 8;
    localparam int FPB_W     = 16;
    localparam int RATIO_W   = 10;
    localparam int SLOT_W    = 7;
    localparam int FRAME_W   = 24;
    localparam int SLEEP_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    // target arithmetic: capacity * percent, then / 100 by reciprocal
    localparam int PROD_W        = CAP_W + PCT_W;           // 32
    localparam int MUL_W         = 63;                      // 32 x 31 product
    localparam logic [30:0] DIV100_MAGIC = 31'h51EB851F;
    localparam int DIV100_SHIFT  = 37;
    localparam int TGT_W         = MUL_W - DIV100_SHIFT;    // 26
    localparam int CMP_W         = RATIO_W + TGT_W;         // 36
    localparam int NEED_W        = FPB_W + SLOT_W;          // 23

    localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};
    localparam logic [RATIO_W-1:0] Q_ONE     = 10'd256;     // 1.0 in Q2.8

    // slot thresholds of the three rules
    localparam logic [SLOT_W-1:0] SLOTS_CRIT = 7'd4;
    localparam logic [SLOT_W-1:0] SLOTS_LOW  = 7'd3;
    localparam logic [SLOT_W-1:0] SLOTS_ONE  = 7'd2;
    localparam logic [SLOT_W-1:0] SLOTS_MIN  = 7'd1;

    // pipeline shape
    localparam int FRONT_STAGES = 3;
    localparam int DEC_STAGES   = 2;
    localparam int NUM_STAGES   = FRONT_STAGES + DEC_STAGES;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RING_CAP,
        REG_TARGET_PCT,
        REG_FRAMES_PER_BATCH,
        REG_OUT_FRAMES_PER_BATCH,
        REG_SUBMIT_CRIT,
        REG_SUBMIT_LOW,
        REG_SLEEP_CRIT,
        REG_SLEEP_LOW
    } cfg_reg_idx_t;

    typedef enum logic [SLEEP_W-1:0] {
        SLEEP_NONE = 2'd0,
        SLEEP_1MS  = 2'd1,
        SLEEP_IDLE = 2'd2
    } sleep_class_t;

    typedef struct packed {
        logic [CAP_W-1:0]   ring_cap;
        logic [PCT_W-1:0]   target_pct;
        logic [FPB_W-1:0]   frames_per_batch;
        logic [FPB_W-1:0]   out_frames_per_batch;
        logic [RATIO_W-1:0] submit_crit;
        logic [RATIO_W-1:0] submit_low;
        logic [RATIO_W-1:0] sleep_crit;
        logic [RATIO_W-1:0] sleep_low;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        ring_cap:             24'd0,
        target_pct:           8'd100,
        frames_per_batch:     16'd0,
        out_frames_per_batch: 16'd0,
        submit_crit:          10'd64,
        submit_low:           10'd128,
        sleep_crit:           10'd128,
        sleep_low:            10'd256
    };

    typedef struct packed {
        logic below_submit_crit;
        logic below_submit_low;
        logic below_one;
        logic below_sleep_crit;
        logic below_sleep_low;
    } ratio_flags_t;

endpackage

// File: sv/blbt_divq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blbt_divq
// Pipelined restoring divider: input frames / frames_per_batch, a few
// quotient bits per front stage. Only quotients below 2**QW are exact.
// ---------------------------------------------------------------------------
module blbt_divq import blbt_pkg::*; #(
    parameter int MAX_BATCHES = 8
) (
    input  logic                            aclk,
    input  logic [FRONT_STAGES-1:0]         stage_en,
    input  logic [FRAME_W-1:0]              frames,
    input  logic [FPB_W-1:0]                frames_per_batch,
    output logic [FRAME_W-1:0]              frames_out,
    output logic [$clog2(MAX_BATCHES)-1:0]  quotient
);

    localparam int QW  = $clog2(MAX_BATCHES);
    localparam int SPS = (QW + FRONT_STAGES - 1) / FRONT_STAGES;
    localparam int RW  = (FRAME_W > FPB_W + QW) ? FRAME_W : FPB_W + QW;

    logic [RW-1:0]      rem_in  [FRONT_STAGES];
    logic [QW-1:0]      q_in    [FRONT_STAGES];
    logic [RW-1:0]      rem_c   [FRONT_STAGES][SPS+1];
    logic [QW-1:0]      q_c     [FRONT_STAGES][SPS+1];
    logic [RW-1:0]      rem_reg [FRONT_STAGES-1];
    logic [QW-1:0]      q_reg   [FRONT_STAGES];
    logic [FRAME_W-1:0] frm_reg [FRONT_STAGES];

    assign rem_in[0] = RW'(frames);
    assign q_in[0]   = '0;

    for (genvar s = 0; s < FRONT_STAGES; s++) begin : g_stage
        if (s > 0) begin : g_link
            assign rem_in[s] = rem_reg[s-1];
            assign q_in[s]   = q_reg[s-1];
        end

        assign rem_c[s][0] = rem_in[s];
        assign q_c[s][0]   = q_in[s];

        for (genvar j = 0; j < SPS; j++) begin : g_bit
            localparam int B = QW - 1 - (s * SPS + j);
            if (B >= 0) begin : g_step
                logic [RW-1:0] dsh;
                logic          take;
                assign dsh  = RW'(frames_per_batch) << B;
                assign take = (rem_c[s][j] >= dsh);
                assign rem_c[s][j+1] = take ? (rem_c[s][j] - dsh) : rem_c[s][j];
                assign q_c[s][j+1]   = q_c[s][j] | (take ? (QW'(1) << B) : '0);
            end else begin : g_pass
                assign rem_c[s][j+1] = rem_c[s][j];
                assign q_c[s][j+1]   = q_c[s][j];
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_en[s]) begin
                q_reg[s] <= q_c[s][SPS];
            end
        end

        if (s < FRONT_STAGES - 1) begin : g_rem
            always_ff @(posedge aclk) begin
                if (stage_en[s]) begin
                    rem_reg[s] <= rem_c[s][SPS];
                end
            end
        end

        if (s == 0) begin : g_frm_first
            always_ff @(posedge aclk) begin
                if (stage_en[s]) begin
                    frm_reg[s] <= frames;
                end
            end
        end else begin : g_frm_next
            always_ff @(posedge aclk) begin
                if (stage_en[s]) begin
                    frm_reg[s] <= frm_reg[s-1];
                end
            end
        end
    end

    assign quotient   = q_reg[FRONT_STAGES-1];
    assign frames_out = frm_reg[FRONT_STAGES-1];

endmodule

// File: sv/blbt_ratio.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blbt_ratio
// Target fill (capacity * percent / 100) and the Q2.8 fill ratio tests,
// three stages: product, reciprocal multiply, cross-multiplied compares.
// ---------------------------------------------------------------------------
module blbt_ratio import blbt_pkg::*; (
    input  logic                    aclk,
    input  logic [FRONT_STAGES-1:0] stage_en,
    input  cfg_t                    cfg,
    input  logic [SLOT_W-1:0]       slots,
    input  logic [FRAME_W-1:0]      fill,
    output ratio_flags_t            flags,
    output logic [FRAME_W-1:0]      target_sat,
    output logic [FRAME_W-1:0]      free_space,
    output logic [SLOT_W-1:0]       slots_out
);

    function automatic logic ratio_below(input logic [CMP_W-1:0]   fill_q,
                                         input logic [RATIO_W-1:0] q,
                                         input logic [TGT_W-1:0]   tgt);
        if (tgt == '0) begin
            return q != '0;
        end
        return fill_q < (CMP_W'(q) * CMP_W'(tgt));
    endfunction

    // stage 1
    logic [PROD_W-1:0]  prod_reg;
    logic [FRAME_W-1:0] fill1_reg, free1_reg, free1_next;
    logic [SLOT_W-1:0]  slots1_reg;
    // stage 2
    logic [MUL_W-1:0]   recip_mul;
    logic [TGT_W-1:0]   tgt2_reg;
    logic [FRAME_W-1:0] fill2_reg, free2_reg;
    logic [SLOT_W-1:0]  slots2_reg;
    // stage 3
    logic [CMP_W-1:0]   fill_q;
    ratio_flags_t       flags_next, flags_reg;
    logic [FRAME_W-1:0] tsat_next, tsat_reg, free3_reg;
    logic [SLOT_W-1:0]  slots3_reg;

    // free ring space, saturated at zero
    assign free1_next = (cfg.ring_cap > fill) ? (cfg.ring_cap - fill) : '0;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            prod_reg   <= PROD_W'(cfg.ring_cap) * PROD_W'(cfg.target_pct);
            fill1_reg  <= fill;
            free1_reg  <= free1_next;
            slots1_reg <= slots;
        end
    end

    // floor(x / 100) for any 32-bit x
    assign recip_mul = MUL_W'(prod_reg) * MUL_W'(DIV100_MAGIC);

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            tgt2_reg   <= recip_mul[DIV100_SHIFT +: TGT_W];
            fill2_reg  <= fill1_reg;
            free2_reg  <= free1_reg;
            slots2_reg <= slots1_reg;
        end
    end

    assign fill_q = CMP_W'({fill2_reg, 8'd0});

    always_comb begin
        flags_next.below_submit_crit = ratio_below(fill_q, cfg.submit_crit, tgt2_reg);
        flags_next.below_submit_low  = ratio_below(fill_q, cfg.submit_low, tgt2_reg);
        flags_next.below_one         = ratio_below(fill_q, Q_ONE, tgt2_reg);
        flags_next.below_sleep_crit  = ratio_below(fill_q, cfg.sleep_crit, tgt2_reg);
        flags_next.below_sleep_low   = ratio_below(fill_q, cfg.sleep_low, tgt2_reg);
        tsat_next = (tgt2_reg > TGT_W'(FRAME_MAX)) ? FRAME_MAX : tgt2_reg[FRAME_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            flags_reg  <= flags_next;
            tsat_reg   <= tsat_next;
            free3_reg  <= free2_reg;
            slots3_reg <= slots2_reg;
        end
    end

    assign flags      = flags_reg;
    assign target_sat = tsat_reg;
    assign free_space = free3_reg;
    assign slots_out  = slots3_reg;

endmodule

// File: sv/blbt_decide.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// blbt_decide
// Slot rules, input-short fallback, output-space veto and sleep class.
// Two stages; the second is the result register.
// ---------------------------------------------------------------------------
module blbt_decide import blbt_pkg::*; #(
    parameter int MAX_BATCHES = 8
) (
    input  logic                            aclk,
    input  logic [DEC_STAGES-1:0]           stage_en,
    input  cfg_t                            cfg,
    input  ratio_flags_t                    flags,
    input  logic [FRAME_W-1:0]              target_sat,
    input  logic [FRAME_W-1:0]              free_space,
    input  logic [SLOT_W-1:0]               slots,
    input  logic [FRAME_W-1:0]              frames,
    input  logic [$clog2(MAX_BATCHES)-1:0]  quotient,
    output logic [SLOT_W-1:0]               batch_count,
    output logic                            submit_now,
    output logic [SLEEP_W-1:0]              sleep_class,
    output logic [FRAME_W-1:0]              target_fill_frames
);

    localparam logic [SLOT_W-1:0] MAX_CNT = SLOT_W'(MAX_BATCHES);

    // stage 4
    logic               bypass_next, kill_next;
    logic [SLOT_W-1:0]  rule_cnt, count_next;
    logic [NEED_W-1:0]  need_in;
    logic               bypass_reg, kill_reg;
    logic [SLOT_W-1:0]  count_reg;
    logic               sleep_crit_reg, sleep_low_reg;
    logic [FRAME_W-1:0] tsat_reg, free_reg;
    // stage 5
    logic [NEED_W-1:0]  need_out;
    logic               veto;
    logic [SLOT_W-1:0]  cnt_next, cnt_reg;
    logic               sub_next, sub_reg;
    sleep_class_t       sleep_next, sleep_reg;
    logic [FRAME_W-1:0] tgt_next, tgt_reg;

    always_comb begin
        bypass_next = (cfg.ring_cap == '0) || (cfg.frames_per_batch == '0);
        kill_next   = bypass_next || (slots == '0)
                      || (frames < FRAME_W'(cfg.frames_per_batch));

        if (flags.below_submit_crit && (slots >= SLOTS_CRIT)) begin
            rule_cnt = (slots < MAX_CNT) ? slots : MAX_CNT;
        end else if (flags.below_submit_low && (slots >= SLOTS_LOW)) begin
            rule_cnt = (slots < SLOTS_LOW) ? slots : SLOTS_LOW;
        end else if (flags.below_one && (slots >= SLOTS_ONE)) begin
            rule_cnt = (slots < SLOTS_ONE) ? slots : SLOTS_ONE;
        end else begin
            rule_cnt = SLOTS_MIN;
        end

        // short on input: fall back to whole batches available, at least one
        need_in = NEED_W'(cfg.frames_per_batch) * NEED_W'(rule_cnt);
        if (frames < FRAME_W'(need_in)) begin
            count_next = (quotient == '0) ? SLOTS_MIN : SLOT_W'(quotient);
        end else begin
            count_next = rule_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            bypass_reg     <= bypass_next;
            kill_reg       <= kill_next;
            count_reg      <= count_next;
            sleep_crit_reg <= flags.below_sleep_crit;
            sleep_low_reg  <= flags.below_sleep_low;
            tsat_reg       <= target_sat;
            free_reg       <= free_space;
        end
    end

    always_comb begin
        need_out = NEED_W'(cfg.out_frames_per_batch) * NEED_W'(count_reg);
        veto     = free_reg < FRAME_W'(need_out);
        tgt_next = bypass_reg ? '0 : tsat_reg;
        if (kill_reg || veto) begin
            cnt_next   = '0;
            sub_next   = 1'b0;
            sleep_next = SLEEP_IDLE;
        end else begin
            cnt_next = count_reg;
            sub_next = 1'b1;
            if (sleep_crit_reg) begin
                sleep_next = SLEEP_NONE;
            end else if (sleep_low_reg) begin
                sleep_next = SLEEP_1MS;
            end else begin
                sleep_next = SLEEP_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            cnt_reg   <= cnt_next;
            sub_reg   <= sub_next;
            sleep_reg <= sleep_next;
            tgt_reg   <= tgt_next;
        end
    end

    assign batch_count        = cnt_reg;
    assign submit_now         = sub_reg;
    assign sleep_class        = sleep_reg;
    assign target_fill_frames = tgt_reg;

endmodule

// File: sv/buffer_level_batch_throttle.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// buffer_level_batch_throttle
// Per-request batch submission and sleep decision from ring fill level.
// ---------------------------------------------------------------------------
// Stateless throttle: each request beat (free slots, input frames ready,
// output fill) yields one result beat (batch count, submit flag, sleep class,
// saturated target fill). The block takes one beat per clock unless m_ready
// holds it off. There are five register stages; the first one loads at the
// edge that accepts the request, and the result is on the m_ ports once it
// is in the last stage, to be taken at an edge with m_ready high.
// The depth is set by the target path: capacity * percent, a 32 x 31
// reciprocal multiply for the divide by 100, then the cross-multiplied Q2.8
// ratio compares, three stages; a restoring divider for the input-short
// fallback (frames / frames_per_batch) runs alongside in the same three
// stages. Two more stages apply the slot rules and the output-space veto,
// the last one being the result register. Each stage keeps its own valid
// bit and only holds when it is full and the stage after it is held, so
// bubbles are squeezed out. A waiting result holds off new beats only once
// all five stages are full.
// Registers are written through cfg_wr_en / cfg_index / cfg_wr_data and
// must only change while no beat is in flight.
// ---------------------------------------------------------------------------
module buffer_level_batch_throttle import blbt_pkg::*; #(
    parameter int MAX_BATCHES = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_wr_data,

    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SLOT_W-1:0]     s_free_slots,
    input  logic [FRAME_W-1:0]    s_input_frames_ready,
    input  logic [FRAME_W-1:0]    s_output_fill_frames,

    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SLOT_W-1:0]     m_batch_count,
    output logic                  m_submit_now,
    output logic [SLEEP_W-1:0]    m_sleep_class,
    output logic [FRAME_W-1:0]    m_target_fill_frames
);

    localparam int QW = $clog2(MAX_BATCHES);

    cfg_t                   cfg_reg, cfg_next;
    logic [NUM_STAGES-1:0]  valid_reg, valid_next;
    logic [NUM_STAGES-1:0]  stage_en;

    ratio_flags_t           flags;
    logic [FRAME_W-1:0]     target_sat, free_space, frames_d;
    logic [SLOT_W-1:0]      slots_d;
    logic [QW-1:0]          quotient;

    // ---- configuration registers ----
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_reg_idx_t'(cfg_index))
                REG_RING_CAP:             cfg_next.ring_cap = cfg_wr_data[CAP_W-1:0];
                REG_TARGET_PCT:           cfg_next.target_pct = cfg_wr_data[PCT_W-1:0];
                REG_FRAMES_PER_BATCH:     cfg_next.frames_per_batch = cfg_wr_data[FPB_W-1:0];
                REG_OUT_FRAMES_PER_BATCH: begin
                    cfg_next.out_frames_per_batch = cfg_wr_data[FPB_W-1:0];
                end
                REG_SUBMIT_CRIT:          cfg_next.submit_crit = cfg_wr_data[RATIO_W-1:0];
                REG_SUBMIT_LOW:           cfg_next.submit_low = cfg_wr_data[RATIO_W-1:0];
                REG_SLEEP_CRIT:           cfg_next.sleep_crit = cfg_wr_data[RATIO_W-1:0];
                REG_SLEEP_LOW:            cfg_next.sleep_low = cfg_wr_data[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---- pipeline flow control ----
    // A stage loads when it is empty or the stage after it is loading.
    always_comb begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_next[0] = stage_en[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            valid_next[k] = stage_en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

    // ---- front: target and ratio tests, quotient in parallel ----
    blbt_ratio u_ratio (
        .aclk       (aclk),
        .stage_en   (stage_en[FRONT_STAGES-1:0]),
        .cfg        (cfg_reg),
        .slots      (s_free_slots),
        .fill       (s_output_fill_frames),
        .flags      (flags),
        .target_sat (target_sat),
        .free_space (free_space),
        .slots_out  (slots_d)
    );

    blbt_divq #(
        .MAX_BATCHES (MAX_BATCHES)
    ) u_divq (
        .aclk             (aclk),
        .stage_en         (stage_en[FRONT_STAGES-1:0]),
        .frames           (s_input_frames_ready),
        .frames_per_batch (cfg_reg.frames_per_batch),
        .frames_out       (frames_d),
        .quotient         (quotient)
    );

    // ---- back: count, veto, result register ----
    blbt_decide #(
        .MAX_BATCHES (MAX_BATCHES)
    ) u_decide (
        .aclk               (aclk),
        .stage_en           (stage_en[NUM_STAGES-1:FRONT_STAGES]),
        .cfg                (cfg_reg),
        .flags              (flags),
        .target_sat         (target_sat),
        .free_space         (free_space),
        .slots              (slots_d),
        .frames             (frames_d),
        .quotient           (quotient),
        .batch_count        (m_batch_count),
        .submit_now         (m_submit_now),
        .sleep_class        (m_sleep_class),
        .target_fill_frames (m_target_fill_frames)
    );

endmodule
